// ===== design/cse_pkg.sv =====
package cse_pkg;

  localparam int unsigned MAX_VARS    = 512;
  localparam int unsigned MAX_CLAUSES = 4096;
  localparam int unsigned MAX_LITS    = 32;

  localparam int unsigned VAR_W  = $clog2(MAX_VARS);
  localparam int unsigned CLS_W  = $clog2(MAX_CLAUSES);
  localparam int unsigned SLOT_W = $clog2(MAX_LITS);
  localparam int unsigned LIT_AW = CLS_W + SLOT_W;
  localparam int unsigned ENT_W  = VAR_W + 1;
  localparam int unsigned LEN_W  = 6;
  localparam int unsigned CNT_W  = 13;
  localparam int unsigned CC_W   = 2 * LEN_W;
  localparam int unsigned OCC_W  = 2 * CNT_W;
  localparam int unsigned CFG_W  = 13;

  localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(MAX_LITS);
  localparam logic [CNT_W-1:0] CLS_MAX   = CNT_W'(MAX_CLAUSES);
  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  localparam logic [1:0] VAL_FALSE = 2'd0;
  localparam logic [1:0] VAL_TRUE  = 2'd1;
  localparam logic [1:0] VAL_OPEN  = 2'd2;

  localparam logic [1:0] STAT_SAT   = 2'd0;
  localparam logic [1:0] STAT_UNDEC = 2'd1;
  localparam logic [1:0] STAT_UNSAT = 2'd2;

  localparam logic CFG_VARS    = 1'b0;
  localparam logic CFG_CLAUSES = 1'b1;

  typedef enum logic [2:0] {
    ACT_WR_LIT   = 3'd0,
    ACT_SET_LEN  = 3'd1,
    ACT_ASSIGN   = 3'd2,
    ACT_EVAL     = 3'd3,
    ACT_RD_VAR   = 3'd4,
    ACT_RD_CLS   = 3'd5,
    ACT_NOP6     = 3'd6,
    ACT_NOP7     = 3'd7
  } action_e;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_RESP, S_CLR, S_LEN_RD, S_LEN_USE, S_L1_RD, S_L1_VAR,
    S_L1_ACC, S_CLS_END, S_L2_RD, S_L2_VAR, S_L2_OCC, S_L2_WR, S_NEXT, S_FINISH
  } state_e;

  typedef struct packed {
    action_e           action;
    logic [CLS_W-1:0]  clause_index;
    logic [SLOT_W-1:0] literal_slot;
    logic [VAR_W-1:0]  variable_index;
    logic              positive_sign;
    logic [LEN_W-1:0]  clause_length;
    logic [1:0]        truth_value;
  } cmd_t;

  typedef struct packed {
    logic [1:0]       formula_status;
    logic [CNT_W-1:0] satisfied_clauses;
    logic [CNT_W-1:0] dead_clauses;
    logic [CNT_W-1:0] plain_occurrences;
    logic [CNT_W-1:0] negated_occurrences;
    logic [LEN_W-1:0] open_literals;
    logic [LEN_W-1:0] satisfying_literals;
  } res_t;

  typedef struct packed {
    logic              lit_we;
    logic [LIT_AW-1:0] lit_addr;
    logic [ENT_W-1:0]  lit_wdata;
    logic              len_we;
    logic [CLS_W-1:0]  len_addr;
    logic [LEN_W-1:0]  len_wdata;
    logic              asg_we;
    logic [VAR_W-1:0]  asg_addr;
    logic [1:0]        asg_wdata;
    logic              occ_we;
    logic [VAR_W-1:0]  occ_addr;
    logic [OCC_W-1:0]  occ_wdata;
    logic              cc_we;
    logic [CLS_W-1:0]  cc_addr;
    logic [CC_W-1:0]   cc_wdata;
  } mem_req_t;

  typedef struct packed {
    logic [ENT_W-1:0] lit_rdata;
    logic [LEN_W-1:0] len_rdata;
    logic [1:0]       asg_rdata;
    logic [OCC_W-1:0] occ_rdata;
    logic [CC_W-1:0]  cc_rdata;
  } mem_rsp_t;

endpackage

// ===== design/cse_tables.sv =====
module cse_tables (
  input  logic              clk_i,
  input  cse_pkg::mem_req_t req_i,
  output cse_pkg::mem_rsp_t rsp_o
);

  logic [cse_pkg::ENT_W-1:0] lit_mem [cse_pkg::MAX_CLAUSES*cse_pkg::MAX_LITS];
  logic [cse_pkg::LEN_W-1:0] len_mem [cse_pkg::MAX_CLAUSES];
  logic [1:0]                asg_mem [cse_pkg::MAX_VARS];
  // {plain, negated} per variable
  logic [cse_pkg::OCC_W-1:0] occ_mem [cse_pkg::MAX_VARS];
  // {open, true} per clause
  logic [cse_pkg::CC_W-1:0]  cc_mem  [cse_pkg::MAX_CLAUSES];

  always_ff @(posedge clk_i) begin
    if (req_i.lit_we) lit_mem[req_i.lit_addr] <= req_i.lit_wdata;
    rsp_o.lit_rdata <= lit_mem[req_i.lit_addr];
  end

  always_ff @(posedge clk_i) begin
    if (req_i.len_we) len_mem[req_i.len_addr] <= req_i.len_wdata;
    rsp_o.len_rdata <= len_mem[req_i.len_addr];
  end

  always_ff @(posedge clk_i) begin
    if (req_i.asg_we) asg_mem[req_i.asg_addr] <= req_i.asg_wdata;
    rsp_o.asg_rdata <= asg_mem[req_i.asg_addr];
  end

  always_ff @(posedge clk_i) begin
    if (req_i.occ_we) occ_mem[req_i.occ_addr] <= req_i.occ_wdata;
    rsp_o.occ_rdata <= occ_mem[req_i.occ_addr];
  end

  always_ff @(posedge clk_i) begin
    if (req_i.cc_we) cc_mem[req_i.cc_addr] <= req_i.cc_wdata;
    rsp_o.cc_rdata <= cc_mem[req_i.cc_addr];
  end

endmodule

// ===== design/cse_ctrl.sv =====
module cse_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  cse_pkg::cmd_t             cmd_i,
  input  logic [cse_pkg::VAR_W-1:0] var_count_i,
  input  logic [cse_pkg::CNT_W-1:0] used_i,
  output logic                      busy_o,
  output logic                      res_valid_o,
  output cse_pkg::res_t             res_o,
  output cse_pkg::mem_req_t         req_o,
  input  cse_pkg::mem_rsp_t         rsp_i
);

  cse_pkg::state_e state_q, state_d;

  logic [cse_pkg::CLS_W-1:0]  sweep_q;
  logic [cse_pkg::CNT_W-1:0]  clause_q;
  logic [cse_pkg::LEN_W-1:0]  lit_q, len_q, opn_q, tru_q;
  logic [cse_pkg::ENT_W-1:0]  ent_q;
  logic [cse_pkg::CNT_W-1:0]  sat_q, dead_q;
  logic                       any_open_q;
  logic [1:0]                 status_q;
  cse_pkg::action_e           act_q;
  logic                       ok_q;

  logic accept;
  logic ent_ok, cmd_ok, lit_last, ent_open;
  logic [cse_pkg::LEN_W-1:0] lit_inc;
  logic [cse_pkg::CNT_W-1:0] plain_inc, neg_inc;

  assign accept   = start_i && (state_q == cse_pkg::S_IDLE);
  assign busy_o   = (state_q != cse_pkg::S_IDLE);
  assign ent_ok   = (ent_q[cse_pkg::ENT_W-1:1] != '0) &&
                    (ent_q[cse_pkg::ENT_W-1:1] <= var_count_i);
  assign cmd_ok   = (cmd_i.variable_index != '0) && (cmd_i.variable_index <= var_count_i);
  assign lit_inc  = lit_q + cse_pkg::LEN_W'(1);
  assign lit_last = (lit_inc == len_q);
  assign ent_open = ent_ok && (rsp_i.asg_rdata == cse_pkg::VAL_OPEN);

  // saturating occurrence increments
  assign plain_inc = (rsp_i.occ_rdata[cse_pkg::OCC_W-1:cse_pkg::CNT_W] == cse_pkg::COUNT_MAX) ?
                     cse_pkg::COUNT_MAX :
                     rsp_i.occ_rdata[cse_pkg::OCC_W-1:cse_pkg::CNT_W] + cse_pkg::CNT_W'(1);
  assign neg_inc   = (rsp_i.occ_rdata[cse_pkg::CNT_W-1:0] == cse_pkg::COUNT_MAX) ?
                     cse_pkg::COUNT_MAX :
                     rsp_i.occ_rdata[cse_pkg::CNT_W-1:0] + cse_pkg::CNT_W'(1);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      cse_pkg::S_INIT: if (sweep_q == '1) state_d = cse_pkg::S_IDLE;
      cse_pkg::S_IDLE: begin
        if (start_i) state_d = (cmd_i.action == cse_pkg::ACT_EVAL) ? cse_pkg::S_CLR
                                                                  : cse_pkg::S_RESP;
      end
      cse_pkg::S_RESP: state_d = cse_pkg::S_IDLE;
      cse_pkg::S_CLR: begin
        if (sweep_q[cse_pkg::VAR_W-1:0] == '1)
          state_d = (used_i == '0) ? cse_pkg::S_FINISH : cse_pkg::S_LEN_RD;
      end
      cse_pkg::S_LEN_RD: state_d = cse_pkg::S_LEN_USE;
      cse_pkg::S_LEN_USE: state_d = (rsp_i.len_rdata == '0) ? cse_pkg::S_CLS_END
                                                            : cse_pkg::S_L1_RD;
      cse_pkg::S_L1_RD: state_d = cse_pkg::S_L1_VAR;
      cse_pkg::S_L1_VAR: state_d = cse_pkg::S_L1_ACC;
      cse_pkg::S_L1_ACC: state_d = lit_last ? cse_pkg::S_CLS_END : cse_pkg::S_L1_RD;
      cse_pkg::S_CLS_END: begin
        if (tru_q != '0 || opn_q == '0) state_d = cse_pkg::S_NEXT;
        else state_d = cse_pkg::S_L2_RD;
      end
      cse_pkg::S_L2_RD: state_d = cse_pkg::S_L2_VAR;
      cse_pkg::S_L2_VAR: state_d = cse_pkg::S_L2_OCC;
      cse_pkg::S_L2_OCC: begin
        if (ent_open) state_d = cse_pkg::S_L2_WR;
        else state_d = lit_last ? cse_pkg::S_NEXT : cse_pkg::S_L2_RD;
      end
      cse_pkg::S_L2_WR: state_d = lit_last ? cse_pkg::S_NEXT : cse_pkg::S_L2_RD;
      cse_pkg::S_NEXT: state_d = (clause_q + cse_pkg::CNT_W'(1) == used_i) ? cse_pkg::S_FINISH
                                                                          : cse_pkg::S_LEN_RD;
      cse_pkg::S_FINISH: state_d = cse_pkg::S_RESP;
      default: state_d = cse_pkg::S_IDLE;
    endcase
  end

  // memory requests and result
  always_comb begin
    req_o = '0;
    req_o.lit_addr = {clause_q[cse_pkg::CLS_W-1:0], lit_q[cse_pkg::SLOT_W-1:0]};
    req_o.len_addr = clause_q[cse_pkg::CLS_W-1:0];
    req_o.asg_addr = rsp_i.lit_rdata[cse_pkg::ENT_W-1:1];
    req_o.occ_addr = ent_q[cse_pkg::ENT_W-1:1];
    req_o.cc_addr  = clause_q[cse_pkg::CLS_W-1:0];
    res_valid_o = 1'b0;
    res_o = '0;
    res_o.formula_status    = status_q;
    res_o.satisfied_clauses = sat_q;
    res_o.dead_clauses      = dead_q;
    unique case (state_q)
      cse_pkg::S_INIT: begin
        req_o.asg_we    = 1'b1;
        req_o.asg_addr  = sweep_q[cse_pkg::VAR_W-1:0];
        req_o.asg_wdata = cse_pkg::VAL_OPEN;
        req_o.occ_we    = 1'b1;
        req_o.occ_addr  = sweep_q[cse_pkg::VAR_W-1:0];
        req_o.cc_we     = 1'b1;
        req_o.cc_addr   = sweep_q;
      end
      cse_pkg::S_IDLE: begin
        req_o.lit_addr  = {cmd_i.clause_index, cmd_i.literal_slot};
        req_o.lit_wdata = {cmd_i.variable_index, cmd_i.positive_sign};
        req_o.len_addr  = cmd_i.clause_index;
        req_o.len_wdata = (cmd_i.clause_length > cse_pkg::LEN_MAX) ? cse_pkg::LEN_MAX
                                                                   : cmd_i.clause_length;
        req_o.asg_addr  = cmd_i.variable_index;
        req_o.asg_wdata = (cmd_i.truth_value > cse_pkg::VAL_OPEN) ? cse_pkg::VAL_OPEN
                                                                  : cmd_i.truth_value;
        req_o.occ_addr  = cmd_i.variable_index;
        req_o.cc_addr   = cmd_i.clause_index;
        req_o.lit_we    = accept && (cmd_i.action == cse_pkg::ACT_WR_LIT);
        req_o.len_we    = accept && (cmd_i.action == cse_pkg::ACT_SET_LEN);
        req_o.asg_we    = accept && (cmd_i.action == cse_pkg::ACT_ASSIGN) && cmd_ok;
      end
      cse_pkg::S_RESP: begin
        res_valid_o = 1'b1;
        if (act_q == cse_pkg::ACT_RD_VAR && ok_q) begin
          res_o.plain_occurrences   = rsp_i.occ_rdata[cse_pkg::OCC_W-1:cse_pkg::CNT_W];
          res_o.negated_occurrences = rsp_i.occ_rdata[cse_pkg::CNT_W-1:0];
        end
        if (act_q == cse_pkg::ACT_RD_CLS) begin
          res_o.open_literals       = rsp_i.cc_rdata[cse_pkg::CC_W-1:cse_pkg::LEN_W];
          res_o.satisfying_literals = rsp_i.cc_rdata[cse_pkg::LEN_W-1:0];
        end
      end
      cse_pkg::S_CLR: begin
        req_o.occ_we   = 1'b1;
        req_o.occ_addr = sweep_q[cse_pkg::VAR_W-1:0];
      end
      cse_pkg::S_L1_VAR, cse_pkg::S_L2_VAR: ;
      cse_pkg::S_CLS_END: begin
        req_o.cc_we    = 1'b1;
        req_o.cc_wdata = {opn_q, tru_q};
      end
      cse_pkg::S_L2_WR: begin
        req_o.occ_we    = 1'b1;
        req_o.occ_wdata = ent_q[0] ? {plain_inc, rsp_i.occ_rdata[cse_pkg::CNT_W-1:0]}
                                   : {rsp_i.occ_rdata[cse_pkg::OCC_W-1:cse_pkg::CNT_W], neg_inc};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= cse_pkg::S_INIT;
      sweep_q    <= '0;
      clause_q   <= '0;
      lit_q      <= '0;
      len_q      <= '0;
      opn_q      <= '0;
      tru_q      <= '0;
      ent_q      <= '0;
      sat_q      <= '0;
      dead_q     <= '0;
      any_open_q <= 1'b0;
      status_q   <= cse_pkg::STAT_SAT;
      act_q      <= cse_pkg::ACT_NOP6;
      ok_q       <= 1'b0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        cse_pkg::S_INIT: sweep_q <= sweep_q + cse_pkg::CLS_W'(1);
        cse_pkg::S_IDLE: begin
          if (start_i) begin
            act_q      <= cmd_i.action;
            ok_q       <= cmd_ok;
            sweep_q    <= '0;
            clause_q   <= '0;
            sat_q      <= (cmd_i.action == cse_pkg::ACT_EVAL) ? '0 : sat_q;
            dead_q     <= (cmd_i.action == cse_pkg::ACT_EVAL) ? '0 : dead_q;
            any_open_q <= (cmd_i.action == cse_pkg::ACT_EVAL) ? 1'b0 : any_open_q;
          end
        end
        cse_pkg::S_CLR: sweep_q <= sweep_q + cse_pkg::CLS_W'(1);
        cse_pkg::S_LEN_USE: begin
          len_q <= rsp_i.len_rdata;
          lit_q <= '0;
          opn_q <= '0;
          tru_q <= '0;
        end
        cse_pkg::S_L1_VAR, cse_pkg::S_L2_VAR: ent_q <= rsp_i.lit_rdata;
        cse_pkg::S_L1_ACC: begin
          if (ent_ok && rsp_i.asg_rdata == {1'b0, ent_q[0]}) tru_q <= tru_q + cse_pkg::LEN_W'(1);
          else if (ent_open) opn_q <= opn_q + cse_pkg::LEN_W'(1);
          lit_q <= lit_inc;
        end
        cse_pkg::S_CLS_END: begin
          lit_q <= '0;
          if (tru_q != '0) sat_q <= sat_q + cse_pkg::CNT_W'(1);
          else if (opn_q == '0) dead_q <= dead_q + cse_pkg::CNT_W'(1);
          else any_open_q <= 1'b1;
        end
        cse_pkg::S_L2_OCC: if (!ent_open) lit_q <= lit_inc;
        cse_pkg::S_L2_WR: lit_q <= lit_inc;
        cse_pkg::S_NEXT: clause_q <= clause_q + cse_pkg::CNT_W'(1);
        cse_pkg::S_FINISH: begin
          if (dead_q != '0) status_q <= cse_pkg::STAT_UNSAT;
          else if (any_open_q) status_q <= cse_pkg::STAT_UNDEC;
          else status_q <= cse_pkg::STAT_SAT;
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== design/cnf_clause_status_evaluator_top.sv =====
// Table writes, assignments and reads answer via S_RESP and the done register; busy holds off new
// commands until S_RESP is over. Evaluate: a pass clears the occurrence counts, then the
// single-port literal, assignment and occurrence memories are walked in turn per clause in use,
// a second walk for clauses left open. After reset a clearing pass (busy high) sets all variables
// unassigned and all counts to zero; config writes are taken during it. Results cannot be stalled.
module cnf_clause_status_evaluator_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [2:0]                   action_i,
  input  logic [cse_pkg::CLS_W-1:0]    clause_index_i,
  input  logic [cse_pkg::SLOT_W-1:0]   literal_slot_i,
  input  logic [cse_pkg::VAR_W-1:0]    variable_index_i,
  input  logic                         positive_sign_i,
  input  logic [cse_pkg::LEN_W-1:0]    clause_length_i,
  input  logic [1:0]                   truth_value_i,
  input  logic                         cfg_we_i,
  input  logic                         cfg_idx_i,
  input  logic [cse_pkg::CFG_W-1:0]    cfg_data_i,
  output logic                         done_o,
  output logic [1:0]                   formula_status_o,
  output logic [cse_pkg::CNT_W-1:0]    satisfied_clauses_o,
  output logic [cse_pkg::CNT_W-1:0]    dead_clauses_o,
  output logic [cse_pkg::CNT_W-1:0]    plain_occurrences_o,
  output logic [cse_pkg::CNT_W-1:0]    negated_occurrences_o,
  output logic [cse_pkg::LEN_W-1:0]    open_literals_o,
  output logic [cse_pkg::LEN_W-1:0]    satisfying_literals_o
);

  logic [cse_pkg::VAR_W-1:0] var_count_q;
  logic [cse_pkg::CNT_W-1:0] clause_count_q, used;
  cse_pkg::cmd_t     cmd;
  cse_pkg::res_t     res, res_q;
  cse_pkg::mem_req_t req;
  cse_pkg::mem_rsp_t rsp;
  logic res_valid, done_q;

  assign cmd.action         = cse_pkg::action_e'(action_i);
  assign cmd.clause_index   = clause_index_i;
  assign cmd.literal_slot   = literal_slot_i;
  assign cmd.variable_index = variable_index_i;
  assign cmd.positive_sign  = positive_sign_i;
  assign cmd.clause_length  = clause_length_i;
  assign cmd.truth_value    = truth_value_i;

  assign used = (clause_count_q > cse_pkg::CLS_MAX) ? cse_pkg::CLS_MAX : clause_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      var_count_q    <= '1;
      clause_count_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        cse_pkg::CFG_VARS:    var_count_q    <= cfg_data_i[cse_pkg::VAR_W-1:0];
        cse_pkg::CFG_CLAUSES: clause_count_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  cse_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .cmd_i       (cmd),
    .var_count_i (var_count_q),
    .used_i      (used),
    .busy_o      (busy),
    .res_valid_o (res_valid),
    .res_o       (res),
    .req_o       (req),
    .rsp_i       (rsp)
  );

  cse_tables u_tables (
    .clk_i (clk_i),
    .req_i (req),
    .rsp_o (rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) res_q <= res;
  end

  assign done_o                = done_q;
  assign formula_status_o      = res_q.formula_status;
  assign satisfied_clauses_o   = res_q.satisfied_clauses;
  assign dead_clauses_o        = res_q.dead_clauses;
  assign plain_occurrences_o   = res_q.plain_occurrences;
  assign negated_occurrences_o = res_q.negated_occurrences;
  assign open_literals_o       = res_q.open_literals;
  assign satisfying_literals_o = res_q.satisfying_literals;

endmodule

// ===== tb/cse_checker.sv =====
`timescale 1ns / 100ps

module cse_checker
  import cse_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  input  logic                 busy,
  input  logic [2:0]           action_i,
  input  logic [CLS_W-1:0]     clause_index_i,
  input  logic [SLOT_W-1:0]    literal_slot_i,
  input  logic [VAR_W-1:0]     variable_index_i,
  input  logic                 positive_sign_i,
  input  logic [LEN_W-1:0]     clause_length_i,
  input  logic [1:0]           truth_value_i,
  input  logic                 cfg_we_i,
  input  logic                 cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 done_o,
  input  logic [1:0]           formula_status_o,
  input  logic [CNT_W-1:0]     satisfied_clauses_o,
  input  logic [CNT_W-1:0]     dead_clauses_o,
  input  logic [CNT_W-1:0]     plain_occurrences_o,
  input  logic [CNT_W-1:0]     negated_occurrences_o,
  input  logic [LEN_W-1:0]     open_literals_o,
  input  logic [LEN_W-1:0]     satisfying_literals_o,
  output int                   fail_cnt_o,
  output int                   beats_seen_o,
  output int                   pending_o
);

  logic [VAR_W-1:0] lit_var [MAX_CLAUSES*MAX_LITS];
  logic             lit_sgn [MAX_CLAUSES*MAX_LITS];
  logic [LEN_W-1:0] len_mem [MAX_CLAUSES];
  logic [1:0]       asg_mem [MAX_VARS];
  logic [CNT_W-1:0] plain_cnt [MAX_VARS];
  logic [CNT_W-1:0] neg_cnt [MAX_VARS];
  logic [LEN_W-1:0] open_cnt [MAX_CLAUSES];
  logic [LEN_W-1:0] true_cnt [MAX_CLAUSES];
  logic [1:0]       status_q;
  logic [CNT_W-1:0] sat_q, dead_q;
  logic [8:0]       vars_q;
  logic [12:0]      clauses_q;
  res_t             expected_q [$];
  int               mismatches;

  assign fail_cnt_o = mismatches;
  assign pending_o  = expected_q.size();

  function automatic bit var_in_use(logic [VAR_W-1:0] v);
    return v >= 1 && v <= vars_q;
  endfunction

  function automatic void evaluate_formula();
    int used, o, t;
    logic [VAR_W-1:0] v;
    logic s;
    bit any_open;
    any_open = 0;
    used = clauses_q > MAX_CLAUSES ? MAX_CLAUSES : clauses_q;
    for (int i = 0; i < MAX_VARS; i++) begin
      plain_cnt[i] = '0;
      neg_cnt[i] = '0;
    end
    sat_q = '0;
    dead_q = '0;
    for (int c = 0; c < used; c++) begin
      o = 0;
      t = 0;
      for (int l = 0; l < len_mem[c]; l++) begin
        v = lit_var[c*MAX_LITS+l];
        s = lit_sgn[c*MAX_LITS+l];
        if (!var_in_use(v)) continue;
        if (asg_mem[v] == {1'b0, s}) t++;
        else if (asg_mem[v] == VAL_OPEN) o++;
      end
      open_cnt[c] = LEN_W'(o);
      true_cnt[c] = LEN_W'(t);
      if (t > 0) begin
        sat_q++;
        continue;
      end
      if (o == 0) dead_q++;
      else any_open = 1;
      for (int l = 0; l < len_mem[c]; l++) begin
        v = lit_var[c*MAX_LITS+l];
        s = lit_sgn[c*MAX_LITS+l];
        if (!var_in_use(v) || asg_mem[v] != VAL_OPEN) continue;
        if (s) begin
          if (plain_cnt[v] != COUNT_MAX) plain_cnt[v]++;
        end else begin
          if (neg_cnt[v] != COUNT_MAX) neg_cnt[v]++;
        end
      end
    end
    status_q = dead_q > 0 ? STAT_UNSAT : (any_open ? STAT_UNDEC : STAT_SAT);
  endfunction

  function automatic res_t predict_beat();
    res_t r;
    action_e act;
    act = action_e'(action_i);
    r = '0;
    case (act)
      ACT_WR_LIT: begin
        lit_var[{clause_index_i, literal_slot_i}] = variable_index_i;
        lit_sgn[{clause_index_i, literal_slot_i}] = positive_sign_i;
      end
      ACT_SET_LEN:
        len_mem[clause_index_i] = clause_length_i > LEN_MAX ? LEN_MAX : clause_length_i;
      ACT_ASSIGN:
        if (var_in_use(variable_index_i))
          asg_mem[variable_index_i] = truth_value_i == 2'd3 ? VAL_OPEN : truth_value_i;
      ACT_EVAL: evaluate_formula();
      ACT_RD_VAR:
        if (var_in_use(variable_index_i)) begin
          r.plain_occurrences = plain_cnt[variable_index_i];
          r.negated_occurrences = neg_cnt[variable_index_i];
        end
      ACT_RD_CLS: begin
        r.open_literals = open_cnt[clause_index_i];
        r.satisfying_literals = true_cnt[clause_index_i];
      end
      default: ;
    endcase
    r.formula_status = status_q;
    r.satisfied_clauses = sat_q;
    r.dead_clauses = dead_q;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    res_t got, want;
    if (!rst_ni) begin
      for (int i = 0; i < MAX_VARS; i++) begin
        asg_mem[i] = VAL_OPEN;
        plain_cnt[i] = '0;
        neg_cnt[i] = '0;
      end
      for (int i = 0; i < MAX_CLAUSES; i++) begin
        open_cnt[i] = '0;
        true_cnt[i] = '0;
        len_mem[i] = '0;
      end
      status_q = STAT_SAT;
      sat_q = '0;
      dead_q = '0;
      vars_q = 9'd511;
      clauses_q = '0;
      expected_q.delete();
      mismatches = 0;
      beats_seen_o = 0;
    end else begin
      if (done_o) begin
        beats_seen_o++;
        got = '{formula_status_o, satisfied_clauses_o, dead_clauses_o, plain_occurrences_o,
                negated_occurrences_o, open_literals_o, satisfying_literals_o};
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("[%0t] result beat with nothing expected", $time);
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("[%0t] mismatch: exp st=%0d sat=%0d dead=%0d p=%0d n=%0d o=%0d t=%0d",
                       $time, want.formula_status, want.satisfied_clauses,
                       want.dead_clauses, want.plain_occurrences, want.negated_occurrences,
                       want.open_literals, want.satisfying_literals,
                       "\n          got st=%0d sat=%0d dead=%0d p=%0d n=%0d o=%0d t=%0d",
                       got.formula_status, got.satisfied_clauses, got.dead_clauses,
                       got.plain_occurrences, got.negated_occurrences,
                       got.open_literals, got.satisfying_literals);
          end
        end
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_VARS) vars_q = cfg_data_i[8:0];
        else clauses_q = cfg_data_i;
      end
      if (start && !busy) expected_q.push_back(predict_beat());
    end
  end

endmodule

// ===== tb/tb_cnf_clause_status_evaluator_top.sv =====
`timescale 1ns / 100ps

module tb_cnf_clause_status_evaluator_top;
  import cse_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [2:0]        action_i = '0;
  logic [CLS_W-1:0]  clause_index_i = '0;
  logic [SLOT_W-1:0] literal_slot_i = '0;
  logic [VAR_W-1:0]  variable_index_i = '0;
  logic              positive_sign_i = 1'b0;
  logic [LEN_W-1:0]  clause_length_i = '0;
  logic [1:0]        truth_value_i = '0;
  logic              cfg_we_i = 1'b0;
  logic              cfg_idx_i = 1'b0;
  logic [CFG_W-1:0]  cfg_data_i = '0;
  logic              done_o;
  logic [1:0]        formula_status_o;
  logic [CNT_W-1:0]  satisfied_clauses_o, dead_clauses_o;
  logic [CNT_W-1:0]  plain_occurrences_o, negated_occurrences_o;
  logic [LEN_W-1:0]  open_literals_o, satisfying_literals_o;
  int fail_cnt, beats_seen, pending;

  // what has been written, so no evaluation ever walks an unwritten entry
  bit          len_written [MAX_CLAUSES];
  logic [5:0]  len_stored [MAX_CLAUSES];
  logic [31:0] lits_written [MAX_CLAUSES];
  int  beats_sent = 0;
  int  eval_cnt = 0;
  int  cur_vars = 511;
  int  cur_clauses = 0;
  int  work_clauses = 4;
  bit  gaps_on = 1'b1;
  int  vars_pick [6] = '{511, 1, 12, 3, 511, 300};

  always #5 clk_i = ~clk_i;

  cnf_clause_status_evaluator_top i_dut (.*);

  cse_checker i_checker (
    .*, .fail_cnt_o(fail_cnt), .beats_seen_o(beats_seen), .pending_o(pending)
  );

  task automatic send_cmd(action_e act, int ci, int slot, int vi, bit sg, int len, int tv);
    int gap;
    if (gaps_on && $urandom_range(99) < 9) begin
      gap = $urandom_range(1, 4);
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start            <= 1'b1;
    action_i         <= act;
    clause_index_i   <= CLS_W'(ci);
    literal_slot_i   <= SLOT_W'(slot);
    variable_index_i <= VAR_W'(vi);
    positive_sign_i  <= sg;
    clause_length_i  <= LEN_W'(len);
    truth_value_i    <= 2'(tv);
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    beats_sent++;
    if (act == ACT_WR_LIT) lits_written[ci][slot] = 1'b1;
    if (act == ACT_SET_LEN) begin
      len_written[ci] = 1'b1;
      len_stored[ci] = 6'(len > MAX_LITS ? MAX_LITS : len);
    end
    if (act == ACT_EVAL) eval_cnt++;
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (beats_seen != beats_sent || busy) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic idx, int val);
    wait_idle();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= CFG_W'(val);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_VARS) cur_vars = val;
    else cur_clauses = val;
  endtask

  function automatic int pick_var();
    int hi;
    hi = cur_vars < 20 ? cur_vars + 1 : 20;
    return $urandom_range(99) < 80 ? $urandom_range(hi) : $urandom_range(511);
  endfunction

  // fill in lengths and literals of every clause in use before an evaluation walks them
  task automatic evaluate_safe();
    int used;
    used = cur_clauses > MAX_CLAUSES ? MAX_CLAUSES : cur_clauses;
    for (int c = 0; c < used; c++) begin
      if (!len_written[c]) send_cmd(ACT_SET_LEN, c, 0, 0, 0, $urandom_range(4), 0);
      for (int s = 0; s < len_stored[c]; s++)
        if (!lits_written[c][s])
          send_cmd(ACT_WR_LIT, c, s, pick_var(), $urandom_range(1), 0, 0);
    end
    send_cmd(ACT_EVAL, $urandom_range(4095), $urandom_range(31), $urandom_range(511),
             $urandom_range(1), $urandom_range(63), $urandom_range(3));
  endtask

  task automatic random_cmd();
    int r, ci, len;
    r = $urandom_range(99);
    ci = $urandom_range(99) < 85 ? $urandom_range(work_clauses + 1) : $urandom_range(4095);
    if (r < 30) begin
      send_cmd(ACT_WR_LIT, ci, $urandom_range(99) < 80 ? $urandom_range(5) : $urandom_range(31),
               pick_var(), $urandom_range(1), $urandom_range(63), $urandom_range(3));
    end else if (r < 40) begin
      len = $urandom_range(99);
      len = len < 85 ? $urandom_range(1, 5) : (len < 92 ? 0 : $urandom_range(32, 63));
      send_cmd(ACT_SET_LEN, ci, $urandom_range(31), $urandom_range(511), $urandom_range(1),
               len, $urandom_range(3));
    end else if (r < 60) begin
      send_cmd(ACT_ASSIGN, ci, $urandom_range(31), pick_var(), $urandom_range(1),
               $urandom_range(63), $urandom_range(3));
    end else if (r < 67) begin
      evaluate_safe();
    end else if (r < 80) begin
      send_cmd(ACT_RD_VAR, ci, $urandom_range(31), pick_var(), $urandom_range(1),
               $urandom_range(63), $urandom_range(3));
    end else if (r < 95) begin
      send_cmd(ACT_RD_CLS, ci, $urandom_range(31), $urandom_range(511), $urandom_range(1),
               $urandom_range(63), $urandom_range(3));
    end else begin
      send_cmd($urandom_range(1) ? ACT_NOP6 : ACT_NOP7, $urandom_range(4095),
               $urandom_range(31), $urandom_range(511), $urandom_range(1),
               $urandom_range(63), $urandom_range(3));
    end
  endtask

  initial begin
    #50ms;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty formula, then three small clauses
    send_cmd(ACT_EVAL, 0, 0, 0, 0, 0, 0);
    write_cfg(CFG_VARS, 511);
    write_cfg(CFG_CLAUSES, 3);
    send_cmd(ACT_SET_LEN, 0, 0, 0, 0, 3, 0);
    send_cmd(ACT_WR_LIT, 0, 0, 1, 1, 0, 0);
    send_cmd(ACT_WR_LIT, 0, 1, 2, 0, 0, 0);
    send_cmd(ACT_WR_LIT, 0, 2, 0, 1, 0, 0);      // variable zero: never true nor open
    send_cmd(ACT_SET_LEN, 1, 0, 0, 0, 2, 0);
    send_cmd(ACT_WR_LIT, 1, 0, 511, 1, 0, 0);
    send_cmd(ACT_WR_LIT, 1, 1, 2, 1, 0, 0);
    send_cmd(ACT_SET_LEN, 2, 0, 0, 0, 0, 0);      // empty clause is dead
    send_cmd(ACT_EVAL, 0, 0, 0, 0, 0, 0);
    send_cmd(ACT_RD_VAR, 0, 0, 2, 0, 0, 0);
    send_cmd(ACT_RD_VAR, 0, 0, 511, 0, 0, 0);
    send_cmd(ACT_RD_CLS, 4095, 31, 0, 0, 0, 0);
    send_cmd(ACT_ASSIGN, 0, 0, 0, 0, 0, 1);       // ignored
    send_cmd(ACT_ASSIGN, 0, 0, 1, 0, 0, VAL_FALSE);
    send_cmd(ACT_ASSIGN, 0, 0, 2, 0, 0, VAL_TRUE);
    send_cmd(ACT_ASSIGN, 0, 0, 511, 0, 0, 3);     // three reads as unassigned
    send_cmd(ACT_SET_LEN, 2, 0, 0, 0, 1, 0);
    send_cmd(ACT_WR_LIT, 2, 0, 1, 1, 0, 0);
    send_cmd(ACT_EVAL, 0, 0, 0, 0, 0, 0);
    send_cmd(ACT_RD_CLS, 0, 0, 0, 0, 0, 0);
    send_cmd(ACT_RD_CLS, 1, 0, 0, 0, 0, 0);
    send_cmd(ACT_NOP6, 4095, 31, 511, 1, 63, 3);
    send_cmd(ACT_NOP7, 0, 0, 0, 0, 0, 0);

    for (int ph = 0; ph < 6; ph++) begin
      write_cfg(CFG_VARS, vars_pick[ph]);
      work_clauses = $urandom_range(1, 12);
      write_cfg(CFG_CLAUSES, ph == 1 ? 0 : $urandom_range(1, work_clauses));
      gaps_on = ph != 3;
      repeat (200) random_cmd();
    end
    gaps_on = 1'b1;

    // larger formula: one variable open in every upper clause, then forced false
    write_cfg(CFG_VARS, 511);
    send_cmd(ACT_ASSIGN, 0, 0, 5, 0, 0, VAL_OPEN);
    for (int c = 16; c < 40; c++) begin
      send_cmd(ACT_SET_LEN, c, 0, 0, 0, 3, 0);
      for (int s = 0; s < 3; s++) send_cmd(ACT_WR_LIT, c, s, 5, 1, 0, 0);
    end
    write_cfg(CFG_CLAUSES, 40);
    evaluate_safe();
    send_cmd(ACT_RD_VAR, 0, 0, 5, 0, 0, 0);
    send_cmd(ACT_RD_CLS, 39, 0, 0, 0, 0, 0);
    send_cmd(ACT_ASSIGN, 0, 0, 5, 0, 0, VAL_FALSE);
    evaluate_safe();
    send_cmd(ACT_RD_VAR, 0, 0, 5, 0, 0, 0);

    wait_idle();
    repeat (20) @(posedge clk_i);
    $display("Sent %0d commands including %0d evaluations over 6 random phases,",
             beats_sent, eval_cnt);
    $display("plus a 40-clause formula sharing one variable, open and then false.");
    if (fail_cnt == 0 && pending == 0 && beats_seen == beats_sent) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
